// ===== hdl/pcvp_pkg.sv =====
`default_nettype none
package pcvp_pkg;

  localparam int MUL_A_W = 40;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = 64;
  localparam int QV_W    = 42;
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = 32;
  localparam int NUM_W   = 62;

  localparam logic signed [31:0] Q30_ONE     = 32'sh4000_0000;
  localparam logic [15:0]        DECAY_RESET = 16'd58982;
  localparam logic signed [63:0] QDOT_LIMIT  = 64'sd274877906944;

  typedef enum logic [2:0] {
    CMD_LOAD_POS  = 3'd0,
    CMD_LOAD_QUAT = 3'd1,
    CMD_LOAD_LIN  = 3'd2,
    CMD_LOAD_ANG  = 3'd3,
    CMD_PREDICT   = 3'd4,
    CMD_READ      = 3'd5
  } cmd_e;

  localparam logic REG_LIN_DECAY = 1'b0;
  localparam logic REG_ANG_DECAY = 1'b1;

  localparam logic [1:0] GRP_POS  = 2'd0;
  localparam logic [1:0] GRP_QUAT = 2'd1;
  localparam logic [1:0] GRP_LIN  = 2'd2;
  localparam logic [1:0] GRP_ANG  = 2'd3;

  // one product term of the quaternion rate
  typedef struct packed {
    logic [1:0] ang;
    logic [1:0] quat;
    logic       neg;
    logic [1:0] row;
    logic       last;
  } qterm_t;

  function automatic qterm_t qterm(input logic [3:0] k);
    qterm_t t;
    unique case (k)
      4'd0:    t = '{ang: 2'd0, quat: 2'd1, neg: 1'b1, row: 2'd0, last: 1'b0};
      4'd1:    t = '{ang: 2'd1, quat: 2'd2, neg: 1'b1, row: 2'd0, last: 1'b0};
      4'd2:    t = '{ang: 2'd2, quat: 2'd3, neg: 1'b1, row: 2'd0, last: 1'b1};
      4'd3:    t = '{ang: 2'd0, quat: 2'd0, neg: 1'b0, row: 2'd1, last: 1'b0};
      4'd4:    t = '{ang: 2'd2, quat: 2'd2, neg: 1'b0, row: 2'd1, last: 1'b0};
      4'd5:    t = '{ang: 2'd1, quat: 2'd3, neg: 1'b1, row: 2'd1, last: 1'b1};
      4'd6:    t = '{ang: 2'd1, quat: 2'd0, neg: 1'b0, row: 2'd2, last: 1'b0};
      4'd7:    t = '{ang: 2'd2, quat: 2'd1, neg: 1'b1, row: 2'd2, last: 1'b0};
      4'd8:    t = '{ang: 2'd0, quat: 2'd3, neg: 1'b0, row: 2'd2, last: 1'b1};
      4'd9:    t = '{ang: 2'd2, quat: 2'd0, neg: 1'b0, row: 2'd3, last: 1'b0};
      4'd10:   t = '{ang: 2'd1, quat: 2'd1, neg: 1'b0, row: 2'd3, last: 1'b0};
      4'd11:   t = '{ang: 2'd0, quat: 2'd2, neg: 1'b1, row: 2'd3, last: 1'b1};
      default: t = '{ang: 2'd0, quat: 2'd0, neg: 1'b0, row: 2'd0, last: 1'b0};
    endcase
    return t;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pcvp_mul.sv =====
`default_nettype none
module pcvp_mul (
  input  wire logic                                 clk_i,
  input  wire logic signed [pcvp_pkg::MUL_A_W-1:0]  a_i,
  input  wire logic signed [pcvp_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [pcvp_pkg::MUL_P_W-1:0]       p_o
);
  import pcvp_pkg::*;

  logic signed [MUL_A_W+MUL_B_W-1:0] full;

  assign full = a_i * b_i;

  // every use keeps its product within 63 bits
  always_ff @(posedge clk_i) begin
    p_o <= full[MUL_P_W-1:0];
  end

endmodule
`default_nettype wire

// ===== hdl/pcvp_sqrt.sv =====
`default_nettype none
module pcvp_sqrt (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [pcvp_pkg::SQ_W-1:0]       x_i,
  output logic      [pcvp_pkg::ROOT_W-1:0]     root_o,
  output logic                                 done_o
);
  import pcvp_pkg::*;

  logic [SQ_W-1:0] rem_q, rem_d, r_q, r_d, bit_q, bit_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [SQ_W:0]   trial;

  assign trial = {1'b0, r_q} + {1'b0, bit_q};

  always_comb begin
    rem_d  = rem_q;
    r_d    = r_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = x_i;
      r_d    = '0;
      bit_d  = {2'b01, {(SQ_W-2){1'b0}}};
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d = rem_q - trial[SQ_W-1:0];
        r_d   = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign root_o = r_q[ROOT_W-1:0];
  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== hdl/pcvp_div.sv =====
`default_nettype none
module pcvp_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [pcvp_pkg::NUM_W-1:0]      num_i,
  input  wire logic [pcvp_pkg::ROOT_W-1:0]     den_i,
  output logic      [pcvp_pkg::ROOT_W-1:0]     quo_o,
  output logic                                 done_o
);
  import pcvp_pkg::*;

  logic [ROOT_W-1:0] rem_q, rem_d, lo_q, lo_d, den_q, den_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [ROOT_W:0]   t, diff;
  logic              ge;

  assign t    = {rem_q, lo_q[ROOT_W-1]};
  assign ge   = t >= {1'b0, den_q};
  assign diff = t - {1'b0, den_q};

  // high part of the dividend is below the divisor, so 32 quotient bits suffice
  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = ROOT_W'(num_i[NUM_W-1:ROOT_W]);
      lo_d   = num_i[ROOT_W-1:0];
      den_d  = den_i;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[ROOT_W-1:0] : t[ROOT_W-1:0];
      lo_d  = {lo_q[ROOT_W-2:0], ge};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    den_q <= den_d;
  end

  assign quo_o  = lo_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== hdl/pose_constant_velocity_predict_unit.sv =====
// Pose predictor holding position, rotation quaternion, linear and angular speed.
// Input channel (in_valid_i / in_stall_o) carries one command per transfer.
// Loads of position or a speed take effect at the transfer and produce no result.
// A quaternion load is normalised, one scaling shift at a time, and produces no
// result; an all-zero quaternion load gives the identity rotation without normalising.
// Predict runs on one shared multiplier (29 products), a 32-step square root and
// four 32-step divisions, then emits four result transfers: position, quaternion,
// linear, angular speed. A step that leaves a zero quaternion skips normalisation.
// Read emits the same four transfers starting the cycle after it is taken.
// The block takes one command at a time; in_stall_o is high while a quaternion load
// normalises and, for predict and read, until the last result is taken. When
// out_stall_i is high the current result holds. last_item_o marks the angular speed
// transfer, norm_fault_o the identity substitution of a zero quaternion.
// Decay registers are written through cfg_we_i / cfg_idx_i / cfg_data_i.
// Reset (rst_ni low, asynchronous) gives zero position and speeds, identity
// rotation, decay factors of 0.9 and no fault.
`default_nettype none
module pose_constant_velocity_predict_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         cmd_i,
  input  wire logic signed [31:0] in_a_i,
  input  wire logic signed [31:0] in_b_i,
  input  wire logic signed [31:0] in_c_i,
  input  wire logic signed [31:0] in_d_i,
  input  wire logic [23:0]        delta_time_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              group_id_o,
  output logic signed [31:0]      comp_first_o,
  output logic signed [31:0]      comp_second_o,
  output logic signed [31:0]      comp_third_o,
  output logic signed [31:0]      comp_fourth_o,
  output logic                    last_item_o,
  output logic                    norm_fault_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i
);
  import pcvp_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_POS    = 11'b000_0000_0010,
    S_QSUM   = 11'b000_0000_0100,
    S_QDT    = 11'b000_0000_1000,
    S_NABS   = 11'b000_0001_0000,
    S_NSHIFT = 11'b000_0010_0000,
    S_SQ     = 11'b000_0100_0000,
    S_SQRT   = 11'b000_1000_0000,
    S_DIV    = 11'b001_0000_0000,
    S_DECAY  = 11'b010_0000_0000,
    S_EMIT   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [3:0]  cnt_q, cnt_d, dec_off;
  logic        ph_q, ph_d, pred_q, pred_d, fault_q, fault_d;
  logic [1:0]  grp_q, grp_d, idx;
  logic [23:0] dt_q, dt_d;
  logic [15:0] lin_decay_q, lin_decay_d, ang_decay_q, ang_decay_d;
  logic signed [63:0] acc_q, acc_d;
  logic [SQ_W-1:0]    sumsq_q, sumsq_d;
  logic [3:0]         neg_q, neg_d;

  logic signed [31:0] pos_q [3], pos_d [3];
  logic signed [31:0] quat_q [4], quat_d [4];
  logic signed [31:0] lin_q [3], lin_d [3];
  logic signed [31:0] ang_q [3], ang_d [3];
  logic signed [QV_W-1:0] vec_q [4], vec_d [4];
  logic [QV_W-1:0]        mag_q [4], mag_d [4];

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [63:0] rnd24, rnd16, term, acc_new, qd_full, qd_c, quo_s;
  logic [QV_W-1:0]    mag_or;
  logic               vec_zero;
  qterm_t             qt;

  logic              sqrt_start, sqrt_done, div_start, div_done;
  logic [ROOT_W-1:0] root, quo;
  logic [NUM_W-1:0]  div_num;

  pcvp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  pcvp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (sumsq_q),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  pcvp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (root),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  assign idx     = cnt_q[1:0];
  assign dec_off = cnt_q - 4'd3;
  assign qt      = qterm(cnt_q);
  assign div_num = {1'b0, mag_q[idx][30:0], 30'd0} + NUM_W'(root[ROOT_W-1:1]);

  assign rnd24   = (prod + 64'sd8388608) >>> 24;
  assign rnd16   = (prod + 64'sd32768) >>> 16;
  assign term    = qt.neg ? -prod : prod;
  assign acc_new = acc_q + (term >>> 2);
  assign qd_full = (acc_new + 64'sd4194304) >>> 23;
  assign qd_c    = (qd_full > QDOT_LIMIT) ? QDOT_LIMIT :
                   (qd_full < -QDOT_LIMIT) ? -QDOT_LIMIT : qd_full;
  assign quo_s   = neg_q[idx] ? -signed'({32'd0, quo}) : signed'({32'd0, quo});
  assign mag_or  = mag_q[0] | mag_q[1] | mag_q[2] | mag_q[3];
  assign vec_zero = (vec_q[0] == '0) && (vec_q[1] == '0) && (vec_q[2] == '0) &&
                    (vec_q[3] == '0);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_POS: begin
        mul_a = MUL_A_W'(lin_q[idx]);
        mul_b = signed'({8'd0, dt_q});
      end
      S_QSUM: begin
        mul_a = MUL_A_W'(ang_q[qt.ang]);
        mul_b = quat_q[qt.quat];
      end
      S_QDT: begin
        mul_a = vec_q[idx][MUL_A_W-1:0];
        mul_b = signed'({8'd0, dt_q});
      end
      S_SQ: begin
        mul_a = signed'(mag_q[idx][MUL_A_W-1:0]);
        mul_b = signed'(mag_q[idx][MUL_B_W-1:0]);
      end
      S_DECAY: begin
        if (cnt_q < 4'd3) begin
          mul_a = MUL_A_W'(lin_q[idx]);
          mul_b = signed'({16'd0, lin_decay_q});
        end else begin
          mul_a = MUL_A_W'(ang_q[dec_off[1:0]]);
          mul_b = signed'({16'd0, ang_decay_q});
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ph_d        = ph_q;
    grp_d       = grp_q;
    pred_d      = pred_q;
    fault_d     = fault_q;
    dt_d        = dt_q;
    acc_d       = acc_q;
    sumsq_d     = sumsq_q;
    neg_d       = neg_q;
    lin_decay_d = lin_decay_q;
    ang_decay_d = ang_decay_q;
    pos_d       = pos_q;
    quat_d      = quat_q;
    lin_d       = lin_q;
    ang_d       = ang_q;
    vec_d       = vec_q;
    mag_d       = mag_q;
    sqrt_start  = 1'b0;
    div_start   = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LIN_DECAY: lin_decay_d = cfg_data_i;
        REG_ANG_DECAY: ang_decay_d = cfg_data_i;
        default:       lin_decay_d = lin_decay_q;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        ph_d  = 1'b0;
        grp_d = GRP_POS;
        if (in_valid_i) begin
          unique case (cmd_i)
            CMD_LOAD_POS: begin
              pos_d[0] = in_a_i;
              pos_d[1] = in_b_i;
              pos_d[2] = in_c_i;
            end
            CMD_LOAD_QUAT: begin
              vec_d[0] = QV_W'(in_a_i);
              vec_d[1] = QV_W'(in_b_i);
              vec_d[2] = QV_W'(in_c_i);
              vec_d[3] = QV_W'(in_d_i);
              pred_d   = 1'b0;
              state_d  = S_NABS;
            end
            CMD_LOAD_LIN: begin
              lin_d[0] = in_a_i;
              lin_d[1] = in_b_i;
              lin_d[2] = in_c_i;
            end
            CMD_LOAD_ANG: begin
              ang_d[0] = in_a_i;
              ang_d[1] = in_b_i;
              ang_d[2] = in_c_i;
            end
            CMD_PREDICT: begin
              dt_d    = delta_time_i;
              pred_d  = 1'b1;
              state_d = S_POS;
            end
            CMD_READ: state_d = S_EMIT;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_POS: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          pos_d[idx] = sat32(64'(pos_q[idx]) + rnd24);
          cnt_d      = cnt_q + 4'd1;
          if (cnt_q == 4'd2) begin
            cnt_d   = '0;
            acc_d   = '0;
            state_d = S_QSUM;
          end
        end
      end
      S_QSUM: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          acc_d = acc_new;
          cnt_d = cnt_q + 4'd1;
          if (qt.last) begin
            vec_d[qt.row] = qd_c[QV_W-1:0];
            acc_d         = '0;
          end
          if (cnt_q == 4'd11) begin
            cnt_d   = '0;
            state_d = S_QDT;
          end
        end
      end
      S_QDT: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          vec_d[idx] = QV_W'(quat_q[idx]) + QV_W'(rnd24);
          cnt_d      = cnt_q + 4'd1;
          if (cnt_q == 4'd3) begin
            cnt_d   = '0;
            state_d = S_NABS;
          end
        end
      end
      S_NABS: begin
        for (int i = 0; i < 4; i++) begin
          neg_d[i] = vec_q[i][QV_W-1];
          mag_d[i] = vec_q[i][QV_W-1] ? QV_W'(-vec_q[i]) : QV_W'(vec_q[i]);
        end
        if (vec_zero) begin
          quat_d[0] = Q30_ONE;
          quat_d[1] = '0;
          quat_d[2] = '0;
          quat_d[3] = '0;
          fault_d   = 1'b1;
          state_d   = pred_q ? S_DECAY : S_IDLE;
        end else begin
          fault_d = 1'b0;
          state_d = S_NSHIFT;
        end
      end
      S_NSHIFT: begin
        // bring the largest magnitude into [2^30, 2^31)
        if (mag_or[QV_W-1:31] != '0) begin
          for (int i = 0; i < 4; i++) mag_d[i] = mag_q[i] >> 1;
        end else if (!mag_or[30]) begin
          for (int i = 0; i < 4; i++) mag_d[i] = mag_q[i] << 1;
        end else begin
          cnt_d   = '0;
          ph_d    = 1'b0;
          sumsq_d = '0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          sumsq_d = sumsq_q + prod;
          cnt_d   = cnt_q + 4'd1;
          if (cnt_q == 4'd3) begin
            cnt_d   = '0;
            state_d = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        if (!ph_q) begin
          sqrt_start = 1'b1;
          ph_d       = 1'b1;
        end else if (sqrt_done) begin
          ph_d    = 1'b0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!ph_q) begin
          div_start = 1'b1;
          ph_d      = 1'b1;
        end else if (div_done) begin
          quat_d[idx] = sat32(quo_s);
          ph_d        = 1'b0;
          cnt_d       = cnt_q + 4'd1;
          if (cnt_q == 4'd3) begin
            cnt_d   = '0;
            state_d = pred_q ? S_DECAY : S_IDLE;
          end
        end
      end
      S_DECAY: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          if (cnt_q < 4'd3) begin
            lin_d[idx] = sat32(rnd16);
          end else begin
            ang_d[dec_off[1:0]] = sat32(rnd16);
          end
          cnt_d = cnt_q + 4'd1;
          if (cnt_q == 4'd5) begin
            cnt_d   = '0;
            grp_d   = GRP_POS;
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!out_stall_i) begin
          if (grp_q == GRP_ANG) begin
            grp_d   = GRP_POS;
            state_d = S_IDLE;
          end else begin
            grp_d = grp_q + 2'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ph_q        <= 1'b0;
      grp_q       <= GRP_POS;
      pred_q      <= 1'b0;
      fault_q     <= 1'b0;
      lin_decay_q <= DECAY_RESET;
      ang_decay_q <= DECAY_RESET;
      pos_q       <= '{default: '0};
      quat_q      <= '{Q30_ONE, 32'sd0, 32'sd0, 32'sd0};
      lin_q       <= '{default: '0};
      ang_q       <= '{default: '0};
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ph_q        <= ph_d;
      grp_q       <= grp_d;
      pred_q      <= pred_d;
      fault_q     <= fault_d;
      lin_decay_q <= lin_decay_d;
      ang_decay_q <= ang_decay_d;
      pos_q       <= pos_d;
      quat_q      <= quat_d;
      lin_q       <= lin_d;
      ang_q       <= ang_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q    <= dt_d;
    acc_q   <= acc_d;
    sumsq_q <= sumsq_d;
    neg_q   <= neg_d;
    vec_q   <= vec_d;
    mag_q   <= mag_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_EMIT);
  assign group_id_o   = grp_q;
  assign last_item_o  = (grp_q == GRP_ANG);
  assign norm_fault_o = fault_q;

  always_comb begin
    comp_fourth_o = '0;
    case (grp_q)
      GRP_POS: begin
        comp_first_o  = pos_q[0];
        comp_second_o = pos_q[1];
        comp_third_o  = pos_q[2];
      end
      GRP_QUAT: begin
        comp_first_o  = quat_q[0];
        comp_second_o = quat_q[1];
        comp_third_o  = quat_q[2];
        comp_fourth_o = quat_q[3];
      end
      GRP_LIN: begin
        comp_first_o  = lin_q[0];
        comp_second_o = lin_q[1];
        comp_third_o  = lin_q[2];
      end
      default: begin
        comp_first_o  = ang_q[0];
        comp_second_o = ang_q[1];
        comp_third_o  = ang_q[2];
      end
    endcase
  end

  a_no_input_during_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while results pending");

  a_fault_means_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q |-> (quat_q[0] == Q30_ONE) && (quat_q[1] == 32'sd0) &&
                (quat_q[2] == 32'sd0) && (quat_q[3] == 32'sd0))
    else $error("fault flag set without identity rotation");

  a_sqrt_done_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == S_SQRT) && ph_q)
    else $error("square root finished outside its step");

  a_div_done_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV) && ph_q)
    else $error("division finished outside its step");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_item_o) |=> !out_valid_o && !in_stall_o)
    else $error("results continue after the last transfer");

endmodule
`default_nettype wire
